>>> design/smrb_pkg.sv
// Shared types and constants for the SPI master register block.
package smrb_pkg;

  localparam int TX_FIFO_DEPTH = 32;
  localparam int RX_FIFO_DEPTH = 32;
  localparam int CS_COUNT      = 4;
  localparam int REG_WORDS     = 64;

  localparam int TX_AW = $clog2(TX_FIFO_DEPTH);
  localparam int TX_LW = $clog2(TX_FIFO_DEPTH + 1);
  localparam int RX_AW = $clog2(RX_FIFO_DEPTH);
  localparam int RX_LW = $clog2(RX_FIFO_DEPTH + 1);
  localparam int RA_W  = $clog2(REG_WORDS);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SLAVE = 2'd2;

  localparam logic [5:0] A_CFG    = 6'd0;
  localparam logic [5:0] A_STAT   = 6'd1;
  localparam logic [5:0] A_IEN    = 6'd2;
  localparam logic [5:0] A_IDIS   = 6'd3;
  localparam logic [5:0] A_IMASK  = 6'd4;
  localparam logic [5:0] A_ENABLE = 6'd5;
  localparam logic [5:0] A_TXD    = 6'd7;
  localparam logic [5:0] A_RXD    = 6'd8;
  localparam logic [5:0] A_IDLE   = 6'd9;
  localparam logic [5:0] A_TXTH   = 6'd10;
  localparam logic [5:0] A_RXTH   = 6'd11;
  localparam logic [5:0] A_ID     = 6'd63;

  localparam logic [31:0] CFG_MASK   = 32'h0002_FFFF;
  localparam logic [31:0] CFG_RESET  = 32'h0002_0000;
  localparam int          CFG_START  = 16;
  localparam int          CFG_CS_LSB = 10;
  localparam logic [31:0] ID_VALUE   = 32'h0109_0106 & 32'h01FF_FFFF;
  localparam logic [6:0]  ST_ALL     = 7'h7F;
  localparam int          ST_UNDER   = 6;
  localparam int          ST_OVER    = 0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  reg_address;
    logic [31:0] write_data;
    logic [7:0]  slave_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        shift_out_valid;
    logic [7:0]  shift_out_byte;
    logic [3:0]  chip_selects;
    logic        irq_level;
  } out_word_t;

  typedef enum logic [1:0] {
    RSEL_REG = 2'd0,
    RSEL_MEM = 2'd1,
    RSEL_RX  = 2'd2
  } rsel_t;

  // Status word: underflow, rx full, rx level, tx full, tx level, mode fail, overflow.
  function automatic logic [6:0] make_status(input logic under, input logic rx_full,
                                             input logic rx_lev, input logic tx_full,
                                             input logic tx_lev, input logic over);
    make_status = {under, rx_full, rx_lev, tx_full, tx_lev, 1'b0, over};
  endfunction

  function automatic logic is_plain(input logic [5:0] addr);
    is_plain = !(addr <= A_ENABLE || addr == A_TXD || addr == A_RXD || addr == A_IDLE ||
                 addr == A_TXTH || addr == A_RXTH || addr == A_ID);
  endfunction

endpackage

>>> design/spi_master_register_block_unit.sv
// SPI master register block: register file, tx/rx byte FIFOs, status and interrupt logic.
// Each accepted word's result word is registered in the output register in the next cycle.
// Throughput: one word per cycle; in_ready drops only while a result waits on out_ready.
// Plain-storage reads and FIFO pops come from memories whose registered read data feeds
// the output; plain storage is single-port, each FIFO dual-port. Reset clears control
// state, FIFO pointers and plain-storage valid bits at once; no clearing pass is needed.
module spi_master_register_block_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smrb_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smrb_pkg::out_word_t  out_data
);
  import smrb_pkg::*;

  logic [31:0]       cfg_r, cfg_nxt;
  logic [6:0]        imask_r, imask_nxt;
  logic              enable_r, enable_nxt;
  logic [7:0]        idle_r, idle_nxt;
  logic [31:0]       txth_r, txth_nxt;
  logic [31:0]       rxth_r, rxth_nxt;
  logic              under_r, under_nxt;
  logic              over_r, over_nxt;
  logic              busy_r, busy_nxt;
  logic [TX_AW-1:0]  tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [TX_LW-1:0]  tx_level_r, tx_level_nxt;
  logic [RX_AW-1:0]  rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RX_LW-1:0]  rx_level_r, rx_level_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [REG_WORDS-1:0] vld_r;

  logic [31:0]       rdata_r, rdata_nxt;
  rsel_t             rsel_r, rsel_nxt;
  logic              sval_r, sval_nxt;
  logic [3:0]        cs_r, cs_nxt;
  logic              irq_r, irq_nxt;
  logic [31:0]       mem_q_r;
  logic              vld_q_r;
  logic [7:0]        tx_q_r, rx_q_r;

  logic [31:0]       reg_mem [REG_WORDS];
  logic [7:0]        tx_mem [TX_FIFO_DEPTH];
  logic [7:0]        rx_mem [RX_FIFO_DEPTH];

  logic              acc, is_rd, is_wr, is_sl;
  logic              tx_push, tx_pop, rx_push, rx_pop, mem_wr, pop_try;
  logic [6:0]        stat_cur, stat_nxt;
  logic [RA_W-1:0]   ra;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign ra       = in_data.reg_address;
  assign is_rd    = in_data.operation == OP_READ;
  assign is_wr    = in_data.operation == OP_WRITE;
  assign is_sl    = in_data.operation == OP_SLAVE;

  assign stat_cur = make_status(under_r, rx_level_r == RX_LW'(RX_FIFO_DEPTH),
                                32'(rx_level_r) >= rxth_r,
                                tx_level_r == TX_LW'(TX_FIFO_DEPTH),
                                32'(tx_level_r) < txth_r, over_r);

  always_comb begin
    cfg_nxt       = cfg_r;
    imask_nxt     = imask_r;
    enable_nxt    = enable_r;
    idle_nxt      = idle_r;
    txth_nxt      = txth_r;
    rxth_nxt      = rxth_r;
    under_nxt     = under_r;
    over_nxt      = over_r;
    busy_nxt      = busy_r;
    tx_head_nxt   = tx_head_r;
    tx_tail_nxt   = tx_tail_r;
    tx_level_nxt  = tx_level_r;
    rx_head_nxt   = rx_head_r;
    rx_tail_nxt   = rx_tail_r;
    rx_level_nxt  = rx_level_r;
    rdata_nxt     = '0;
    rsel_nxt      = RSEL_REG;
    sval_nxt      = 1'b0;
    tx_push       = 1'b0;
    tx_pop        = 1'b0;
    rx_push       = 1'b0;
    rx_pop        = 1'b0;
    mem_wr        = 1'b0;
    pop_try       = 1'b0;

    if (acc && is_rd) begin
      if (is_plain(in_data.reg_address)) begin
        rsel_nxt = RSEL_MEM;
      end else begin
        unique case (in_data.reg_address)
          A_CFG:    rdata_nxt = cfg_r;
          A_STAT:   rdata_nxt = {25'd0, stat_cur};
          A_IMASK:  rdata_nxt = {25'd0, imask_r};
          A_ENABLE: rdata_nxt = {31'd0, enable_r};
          A_IDLE:   rdata_nxt = {24'd0, idle_r};
          A_TXTH:   rdata_nxt = txth_r;
          A_RXTH:   rdata_nxt = rxth_r;
          A_ID:     rdata_nxt = ID_VALUE;
          A_RXD:    rx_pop = rx_level_r != '0;
          default:  rdata_nxt = '0;
        endcase
        if (rx_pop) begin
          rsel_nxt = RSEL_RX;
        end
      end
    end

    if (acc && is_wr) begin
      if (is_plain(in_data.reg_address)) begin
        mem_wr = 1'b1;
      end else begin
        unique case (in_data.reg_address)
          A_CFG: begin
            cfg_nxt = in_data.write_data & CFG_MASK;
            pop_try = in_data.write_data[CFG_START] && !busy_r;
          end
          A_STAT: begin
            under_nxt = under_r & ~in_data.write_data[ST_UNDER];
            over_nxt  = over_r & ~in_data.write_data[ST_OVER];
          end
          A_IEN:    imask_nxt = imask_r | (in_data.write_data[6:0] & ST_ALL);
          A_IDIS:   imask_nxt = imask_r & ~(in_data.write_data[6:0] & ST_ALL);
          A_ENABLE: enable_nxt = in_data.write_data[0];
          A_IDLE:   idle_nxt = in_data.write_data[7:0];
          A_TXTH:   txth_nxt = in_data.write_data;
          A_RXTH:   rxth_nxt = in_data.write_data;
          A_TXD:    tx_push = tx_level_r != TX_LW'(TX_FIFO_DEPTH);
          default:  ;
        endcase
      end
    end

    if (acc && is_sl && busy_r) begin
      pop_try = 1'b1;
      if (rx_level_r == RX_LW'(RX_FIFO_DEPTH)) begin
        over_nxt = 1'b1;
      end else begin
        rx_push = 1'b1;
      end
    end

    if (pop_try) begin
      if (tx_level_r == '0) begin
        under_nxt = 1'b1;
        busy_nxt  = 1'b0;
      end else begin
        tx_pop   = 1'b1;
        sval_nxt = 1'b1;
        busy_nxt = 1'b1;
      end
    end

    if (tx_push) begin
      tx_tail_nxt  = (tx_tail_r == TX_AW'(TX_FIFO_DEPTH - 1)) ? '0 : tx_tail_r + 1'b1;
      tx_level_nxt = tx_level_r + 1'b1;
    end
    if (tx_pop) begin
      tx_head_nxt  = (tx_head_r == TX_AW'(TX_FIFO_DEPTH - 1)) ? '0 : tx_head_r + 1'b1;
      tx_level_nxt = tx_level_r - 1'b1;
    end
    if (rx_push) begin
      rx_tail_nxt  = (rx_tail_r == RX_AW'(RX_FIFO_DEPTH - 1)) ? '0 : rx_tail_r + 1'b1;
      rx_level_nxt = rx_level_r + 1'b1;
    end
    if (rx_pop) begin
      rx_head_nxt  = (rx_head_r == RX_AW'(RX_FIFO_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
      rx_level_nxt = rx_level_r - 1'b1;
    end

    stat_nxt = make_status(under_nxt, rx_level_nxt == RX_LW'(RX_FIFO_DEPTH),
                           32'(rx_level_nxt) >= rxth_nxt,
                           tx_level_nxt == TX_LW'(TX_FIFO_DEPTH),
                           32'(tx_level_nxt) < txth_nxt, over_nxt);
    irq_nxt = |(imask_nxt & stat_nxt);

    // lowest zero in the CS field drives its line low
    cs_nxt = 4'hF;
    for (int i = CS_COUNT - 1; i >= 0; i--) begin
      if (!cfg_nxt[CFG_CS_LSB + i]) begin
        cs_nxt = 4'hF & ~(4'h1 << i);
      end
    end

    out_valid_nxt = acc ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      imask_r     <= '0;
      enable_r    <= 1'b0;
      idle_r      <= 8'hFF;
      txth_r      <= 32'd1;
      rxth_r      <= 32'd1;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      busy_r      <= 1'b0;
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      tx_level_r  <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      rx_level_r  <= '0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      cfg_r       <= cfg_nxt;
      imask_r     <= imask_nxt;
      enable_r    <= enable_nxt;
      idle_r      <= idle_nxt;
      txth_r      <= txth_nxt;
      rxth_r      <= rxth_nxt;
      under_r     <= under_nxt;
      over_r      <= over_nxt;
      busy_r      <= busy_nxt;
      tx_head_r   <= tx_head_nxt;
      tx_tail_r   <= tx_tail_nxt;
      tx_level_r  <= tx_level_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_tail_r   <= rx_tail_nxt;
      rx_level_r  <= rx_level_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_wr) begin
        vld_r[ra] <= 1'b1;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r <= rdata_nxt;
      rsel_r  <= rsel_nxt;
      sval_r  <= sval_nxt;
      cs_r    <= cs_nxt;
      irq_r   <= irq_nxt;
      mem_q_r <= reg_mem[ra];
      vld_q_r <= vld_r[ra];
      tx_q_r  <= tx_mem[tx_head_r];
      rx_q_r  <= rx_mem[rx_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      reg_mem[ra] <= in_data.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (tx_push) begin
      tx_mem[tx_tail_r] <= in_data.write_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_push) begin
      rx_mem[rx_tail_r] <= in_data.slave_byte;
    end
  end

  always_comb begin
    case (rsel_r)
      RSEL_MEM: out_data.read_data = vld_q_r ? mem_q_r : '0;
      RSEL_RX:  out_data.read_data = {24'd0, rx_q_r};
      default:  out_data.read_data = rdata_r;
    endcase
    out_data.shift_out_valid = sval_r;
    out_data.shift_out_byte  = sval_r ? tx_q_r : 8'd0;
    out_data.chip_selects    = cs_r;
    out_data.irq_level       = irq_r;
  end

  assign out_valid = out_valid_r;

  a_tx_level: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tx_level_r) <= TX_FIFO_DEPTH)
    else $error("tx level above depth");

  a_rx_level: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rx_level_r) <= RX_FIFO_DEPTH)
    else $error("rx level above depth");

  a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sval_r |-> busy_r)
    else $error("byte shifted out with no transfer running");

  a_cs_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(~cs_r))
    else $error("more than one chip select low");

  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    tx_pop |=> tx_level_r == $past(tx_level_r) - 1'b1)
    else $error("tx pop did not lower the level");

endmodule
